// ----- rtl/uud_pkg.sv -----
// uudecode stream package: phase codes, result kinds, field widths and the
// result record passed from the decoder core to the output register.
// No dependencies; imported by every module of the block.
package uud_pkg;

	// width of the saturating byte counter
	localparam int COUNT_WIDTH = 32;
	localparam int TOTAL_WIDTH = 32;
	localparam int CHAR_WIDTH  = 8;
	localparam int SEXTET_WIDTH = 6;

	// result kinds
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_FAIL = 2'd2;

	// match index that marks a line being skipped while searching
	localparam logic [2:0] SKIP_MARK = 3'd7;
	localparam logic [2:0] BEGIN_LEN = 3'd6;
	localparam logic [2:0] END_LEN   = 3'd4;

	localparam logic [7:0] CHAR_NL    = 8'h0a;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// decoder phase, one-hot
	typedef enum logic [7:0] {
		PH_SEARCH     = 8'b0000_0001,
		PH_HEADER     = 8'b0000_0010,
		PH_LINE_START = 8'b0000_0100,
		PH_DATA       = 8'b0000_1000,
		PH_DATA_REST  = 8'b0001_0000,
		PH_ZERO_REST  = 8'b0010_0000,
		PH_END_MATCH  = 8'b0100_0000,
		PH_IDLE       = 8'b1000_0000
	} phase_t;

	// one result item
	typedef struct packed {
		logic                   valid;
		logic [CHAR_WIDTH-1:0]  out_byte;
		logic [1:0]             kind;
		logic [TOTAL_WIDTH-1:0] total_bytes;
	} result_t;

	// characters of the header keyword "begin "
	function automatic logic [7:0] begin_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h62;
			3'd1: c = 8'h65;
			3'd2: c = 8'h67;
			3'd3: c = 8'h69;
			3'd4: c = 8'h6e;
			3'd5: c = CHAR_SPACE;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// characters of the trailer line "end\n"
	function automatic logic [7:0] end_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h65;
			3'd1: c = 8'h6e;
			3'd2: c = 8'h64;
			3'd3: c = CHAR_NL;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// low bits of the byte counter as reported on the output
	function automatic logic [TOTAL_WIDTH-1:0] total_low(input logic [COUNT_WIDTH-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[TOTAL_WIDTH-1:0];
	endfunction

endpackage

// ----- rtl/uud_core.sv -----
// uudecode decoder core: phase machine, line and group state, byte counter.
// Computes the result of the held character combinationally; state updates on fire.
// Depends on uud_pkg.
module uud_core import uud_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [CHAR_WIDTH-1:0] in_char,
	input  logic                  end_of_input,
	output result_t               res
);

	phase_t                  phase_q, phase_d;
	logic [2:0]              match_index_q, match_index_d;
	logic [5:0]              bytes_left_q, bytes_left_d;
	logic [1:0]              group_position_q, group_position_d;
	logic [5:0]              previous_sextet_q, previous_sextet_d;
	logic [COUNT_WIDTH-1:0]  byte_total_q, byte_total_d;
	logic [SEXTET_WIDTH-1:0] sx;
	logic [7:0]              data_byte;
	logic                    have;

	// sextet value of the character and the byte it completes
	always_comb begin
		sx = SEXTET_WIDTH'(in_char - CHAR_SPACE);
		have = 1'b1;
		case (group_position_q)
			2'd1: data_byte = {previous_sextet_q, sx[5:4]};
			2'd2: data_byte = {previous_sextet_q[3:0], sx[5:2]};
			2'd3: data_byte = {previous_sextet_q[1:0], sx};
			default: begin
				data_byte = 8'h00;
				have = 1'b0;
			end
		endcase
	end

	// next state and result
	always_comb begin
		phase_d = phase_q;
		match_index_d = match_index_q;
		bytes_left_d = bytes_left_q;
		group_position_d = group_position_q;
		previous_sextet_d = previous_sextet_q;
		byte_total_d = byte_total_q;
		res.valid = 1'b0;
		res.out_byte = 8'h00;
		res.kind = KIND_BYTE;

		if (phase_q == PH_IDLE) begin
			phase_d = PH_IDLE;
		end else if (end_of_input) begin
			phase_d = PH_IDLE;
			res.valid = 1'b1;
			res.kind = KIND_FAIL;
		end else begin
			case (phase_q)
				PH_SEARCH: begin
					if (match_index_q == SKIP_MARK) begin
						if (in_char == CHAR_NL)
							match_index_d = 3'd0;
					end else if (match_index_q < BEGIN_LEN
							&& in_char == begin_char(match_index_q)) begin
						if (match_index_q == BEGIN_LEN - 3'd1) begin
							phase_d = PH_HEADER;
							match_index_d = 3'd0;
						end else begin
							match_index_d = match_index_q + 3'd1;
						end
					end else begin
						match_index_d = (in_char == CHAR_NL) ? 3'd0 : SKIP_MARK;
					end
				end
				PH_HEADER: begin
					if (in_char == CHAR_NL)
						phase_d = PH_LINE_START;
				end
				PH_LINE_START: begin
					if (in_char != CHAR_NL) begin
						if (sx == 6'd0) begin
							phase_d = PH_ZERO_REST;
						end else begin
							bytes_left_d = sx;
							group_position_d = 2'd0;
							phase_d = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					if (in_char == CHAR_NL) begin
						phase_d = PH_LINE_START;
						bytes_left_d = 6'd0;
						group_position_d = 2'd0;
					end else begin
						previous_sextet_d = sx;
						group_position_d = group_position_q + 2'd1;
						if (have && bytes_left_q != 6'd0) begin
							bytes_left_d = bytes_left_q - 6'd1;
							if (bytes_left_q == 6'd1) begin
								phase_d = PH_DATA_REST;
								group_position_d = 2'd0;
							end
							if (byte_total_q != {COUNT_WIDTH{1'b1}})
								byte_total_d = byte_total_q + COUNT_WIDTH'(1);
							res.valid = 1'b1;
							res.out_byte = data_byte;
						end
					end
				end
				PH_DATA_REST: begin
					if (in_char == CHAR_NL)
						phase_d = PH_LINE_START;
				end
				PH_ZERO_REST: begin
					if (in_char == CHAR_NL) begin
						phase_d = PH_END_MATCH;
						match_index_d = 3'd0;
					end
				end
				PH_END_MATCH: begin
					if (match_index_q < END_LEN && in_char == end_char(match_index_q)) begin
						match_index_d = match_index_q + 3'd1;
						if (match_index_q == END_LEN - 3'd1) begin
							phase_d = PH_IDLE;
							res.valid = 1'b1;
							res.kind = KIND_DONE;
						end
					end else begin
						phase_d = PH_IDLE;
						res.valid = 1'b1;
						res.kind = KIND_FAIL;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
		res.total_bytes = total_low(byte_total_d);
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			match_index_q <= 3'd0;
			bytes_left_q <= 6'd0;
			group_position_q <= 2'd0;
			previous_sextet_q <= 6'd0;
			byte_total_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			match_index_q <= match_index_d;
			bytes_left_q <= bytes_left_d;
			group_position_q <= group_position_d;
			previous_sextet_q <= previous_sextet_d;
			byte_total_q <= byte_total_d;
		end
	end

	// once finished or failed the core stays idle
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |=> phase_q == PH_IDLE)
		else $error("uud_core: left idle after a report");

	// a report is only ever produced outside idle
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> phase_q != PH_IDLE)
		else $error("uud_core: result while idle");

	// trailer match index stays within the keyword
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_END_MATCH |-> match_index_q < END_LEN)
		else $error("uud_core: trailer match index out of range");

	// a line in data always has bytes left to give
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> bytes_left_q != 6'd0)
		else $error("uud_core: data phase with no bytes left");

endmodule

// ----- rtl/uud_out_reg.sv -----
// uudecode output register: holds one result until the master side takes it.
// Packs the result fields onto the stream bus.
// Depends on uud_pkg.
module uud_out_reg import uud_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  result_t     res,
	output logic        free,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // out_byte [7:0], total_bytes [39:8]
	output logic [1:0]  m_tuser    // kind [1:0]
);

	logic                   valid_q;
	logic [7:0]             byte_q;
	logic [1:0]             kind_q;
	logic [TOTAL_WIDTH-1:0] total_q;

	assign free = !valid_q || m_tready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= res.out_byte;
			kind_q <= res.kind;
			total_q <= res.total_bytes;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {total_q, byte_q};
	assign m_tuser = kind_q;

	// a waiting result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("uud_out_reg: load while a result waits");

endmodule

// ----- rtl/uudecode_stream.sv -----
// uudecode stream top level: input stage, decoder core and output register.
// Depends on uud_pkg, uud_core and uud_out_reg.
//
// Usage:
//   Slave side takes one encoded character per transfer: s_tdata carries
//   in_char, s_tuser carries end_of_input (character then ignored).
//   Master side gives one result per transfer: a decoded byte with the
//   running total, or a single finish or failure report with the total.
//   A result reaches the master side through the input stage, then the
//   output register. Throughput: one character per cycle, sustained while
//   no result waits for a stalled master side.
//   The input stage can hold one character while a result waits, so the
//   slave side keeps taking characters until a second result would be
//   needed; characters that give no result pass even when the master stalls.
//   After a finish or failure report the block takes and drops characters
//   until reset. Reset clears the search state, counters and both stages.
module uudecode_stream import uud_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_char [7:0]
	input  logic        s_tuser,   // end_of_input [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // out_byte [7:0], total_bytes [39:8]
	output logic [1:0]  m_tuser    // kind [1:0]
);

	logic            valid_s1;
	logic [7:0]      char_s1;
	logic            eoi_s1;
	logic            advance;
	logic            out_free;
	result_t         res;

	// the held character moves on unless its result has nowhere to go
	assign advance = valid_s1 && (!res.valid || out_free);
	assign s_tready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			eoi_s1 <= s_tuser;
		end
	end

	uud_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.in_char      (char_s1),
		.end_of_input (eoi_s1),
		.res          (res)
	);

	uud_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && res.valid),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// a stalled input stage holds its character
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(char_s1) && $stable(eoi_s1))
		else $error("uudecode_stream: held character lost");

endmodule

// ----- dv/tb_top.sv -----
// testbench for uudecode_stream: drives one encoded text stream character by character
// and checks every decoded byte and the closing report against a built-in decoder model or typed rows.
// Depends on uud_pkg and the uudecode_stream RTL.
module tb_top;
	import uud_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 1450;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS  = 10;

	localparam logic [47:0] BEGIN_TEXT = "begin ";
	localparam logic [31:0] END_TEXT   = "end\n";
	localparam logic [63:0] TOTAL_MAX  = (64'd1 << COUNT_WIDTH) - 64'd1;

	// one decoded result as seen on the master side
	typedef struct packed {
		logic [7:0]  out_byte;
		logic [1:0]  kind;
		logic [31:0] total;
	} uud_result_t;

	// one directed character with an optional hand-written expectation
	typedef struct packed {
		logic [7:0]  ch;
		logic        eoi;
		logic        typed;
		logic        has_res;
		uud_result_t res;
	} stim_row_t;

	localparam int N_DIRECTED = 27;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		// partial keyword then a skipped line
		'{"b",   1'b0, 1'b1, 1'b0, '0},
		'{"x",   1'b0, 1'b1, 1'b0, '0},
		'{"\n",  1'b0, 1'b1, 1'b0, '0},
		// header line with mode text
		'{"b",   1'b0, 1'b1, 1'b0, '0},
		'{"e",   1'b0, 1'b1, 1'b0, '0},
		'{"g",   1'b0, 1'b1, 1'b0, '0},
		'{"i",   1'b0, 1'b1, 1'b0, '0},
		'{"n",   1'b0, 1'b1, 1'b0, '0},
		'{" ",   1'b0, 1'b1, 1'b0, '0},
		'{"6",   1'b0, 1'b1, 1'b0, '0},
		'{"\n",  1'b0, 1'b1, 1'b0, '0},
		// empty data line
		'{"\n",  1'b0, 1'b1, 1'b0, '0},
		// count two: all-ones byte, then a byte, then ignored tail
		'{"\"",  1'b0, 1'b1, 1'b0, '0},
		'{"_",   1'b0, 1'b1, 1'b0, '0},
		'{"_",   1'b0, 1'b1, 1'b1, '{8'hff, KIND_BYTE, 32'd1}},
		'{" ",   1'b0, 1'b0, 1'b0, '0},
		'{8'hff, 1'b0, 1'b1, 1'b0, '0},
		'{"\n",  1'b0, 1'b1, 1'b0, '0},
		// count one from a high count character: all-zero byte
		'{8'he1, 1'b0, 1'b1, 1'b0, '0},
		'{" ",   1'b0, 1'b1, 1'b0, '0},
		'{" ",   1'b0, 1'b1, 1'b1, '{8'h00, KIND_BYTE, 32'd3}},
		'{"\n",  1'b0, 1'b1, 1'b0, '0},
		// full count line cut short by a newline
		'{"_",   1'b0, 1'b1, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, 1'b0, '0},
		'{8'h7f, 1'b0, 1'b0, 1'b0, '0},
		'{"\n",  1'b0, 1'b1, 1'b0, '0}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	// hand-written expectation travelling with the character
	logic        row_typed;
	logic        row_has;
	uud_result_t row_res;

	// decoder model state
	phase_t      dec_phase;
	logic [2:0]  dec_match;
	logic [5:0]  dec_left;
	logic [1:0]  dec_group;
	logic [5:0]  dec_prev;
	logic [63:0] dec_total;

	uud_result_t expected_results [$];
	int          mismatches;
	int          items_sent;
	int          idle_mode;
	int          stall_cycles;

	uudecode_stream u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// decoder model: one character in, at most one result out
	function automatic logic decode_char(input logic [7:0] c, input logic eoi,
			output uud_result_t r);
		logic [7:0] diff;
		logic [5:0] s;
		logic [7:0] b;
		logic       have;
		r = '0;
		b = '0;
		have = 1'b0;
		diff = c - CHAR_SPACE;
		s = diff[5:0];
		if (dec_phase == PH_IDLE)
			return 1'b0;
		if (eoi) begin
			dec_phase = PH_IDLE;
			r = '{8'h00, KIND_FAIL, dec_total[31:0]};
			return 1'b1;
		end
		case (dec_phase)
			PH_SEARCH: begin
				if (dec_match == SKIP_MARK) begin
					if (c == CHAR_NL)
						dec_match = '0;
				end else if (dec_match < BEGIN_LEN &&
						c == BEGIN_TEXT[8 * (5 - int'(dec_match)) +: 8]) begin
					dec_match = dec_match + 3'd1;
					if (dec_match == BEGIN_LEN) begin
						dec_phase = PH_HEADER;
						dec_match = '0;
					end
				end else begin
					dec_match = (c == CHAR_NL) ? 3'd0 : SKIP_MARK;
				end
			end
			PH_HEADER: begin
				if (c == CHAR_NL)
					dec_phase = PH_LINE_START;
			end
			PH_LINE_START: begin
				if (c != CHAR_NL) begin
					if (s == 6'd0) begin
						dec_phase = PH_ZERO_REST;
					end else begin
						dec_left = s;
						dec_group = '0;
						dec_phase = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				// newline ends the line early, pending bytes are dropped
				if (c == CHAR_NL) begin
					dec_phase = PH_LINE_START;
					dec_left = '0;
					dec_group = '0;
					return 1'b0;
				end
				case (dec_group)
					2'd1: begin b = {dec_prev, s[5:4]}; have = 1'b1; end
					2'd2: begin b = {dec_prev[3:0], s[5:2]}; have = 1'b1; end
					2'd3: begin b = {dec_prev[1:0], s}; have = 1'b1; end
					default: have = 1'b0;
				endcase
				dec_prev = s;
				dec_group = dec_group + 2'd1;
				if (!have || dec_left == 6'd0)
					return 1'b0;
				dec_left = dec_left - 6'd1;
				if (dec_left == 6'd0) begin
					dec_phase = PH_DATA_REST;
					dec_group = '0;
				end
				if (dec_total < TOTAL_MAX)
					dec_total = dec_total + 64'd1;
				r = '{b, KIND_BYTE, dec_total[31:0]};
				return 1'b1;
			end
			PH_DATA_REST: begin
				if (c == CHAR_NL)
					dec_phase = PH_LINE_START;
			end
			PH_ZERO_REST: begin
				if (c == CHAR_NL) begin
					dec_phase = PH_END_MATCH;
					dec_match = '0;
				end
			end
			PH_END_MATCH: begin
				if (dec_match < END_LEN && c == END_TEXT[8 * (3 - int'(dec_match)) +: 8]) begin
					dec_match = dec_match + 3'd1;
					if (dec_match == END_LEN) begin
						dec_phase = PH_IDLE;
						r = '{8'h00, KIND_DONE, dec_total[31:0]};
						return 1'b1;
					end
				end else begin
					dec_phase = PH_IDLE;
					r = '{8'h00, KIND_FAIL, dec_total[31:0]};
					return 1'b1;
				end
			end
			default: dec_phase = PH_IDLE;
		endcase
		return 1'b0;
	endfunction

	// prediction on slave transfers, checking on master transfers
	always @(posedge clk) begin : monitor
		uud_result_t pred;
		uud_result_t seen;
		logic        got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				got = decode_char(s_tdata, s_tuser, pred);
				if (row_typed) begin
					got = row_has;
					pred = row_res;
				end
				if (got)
					expected_results.push_back(pred);
			end
			if (m_tvalid && m_tready) begin
				seen = '{m_tdata[7:0], m_tuser, m_tdata[39:8]};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result: byte %h kind %0d total %0d",
							seen.out_byte, seen.kind, seen.total);
				end else begin
					pred = expected_results.pop_front();
					if (seen.out_byte !== pred.out_byte || seen.kind !== pred.kind ||
							seen.total !== pred.total) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"mismatch: expected byte %h kind %0d total %0d,",
								" got byte %h kind %0d total %0d"},
								pred.out_byte, pred.kind, pred.total,
								seen.out_byte, seen.kind, seen.total);
					end
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	// receiver back-pressure, heavy first, light second, none last
	always @(negedge clk) begin
		case (idle_mode)
			0: m_tready <= ($urandom_range(0, 99) >= 80);
			1: m_tready <= ($urandom_range(0, 99) >= 31);
			default: m_tready <= 1'b1;
		endcase
	end

	// send one character, waiting out random gaps and back-pressure
	task automatic send_char(input logic [7:0] c, input logic eoi,
			input logic typed = 1'b0, input logic has = 1'b0,
			input uud_result_t res = '0);
		int gap_pct;
		gap_pct = (idle_mode == 0) ? 31 : (idle_mode == 1) ? 80 : 0;
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tdata   <= c;
		s_tuser   <= eoi;
		row_typed <= typed;
		row_has   <= has;
		row_res   <= res;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
		idle_mode = (items_sent < 480) ? 0 : (items_sent < 960) ? 1 : 2;
	endtask

	// any character but newline
	function automatic logic [7:0] data_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == CHAR_NL);
		return c;
	endfunction

	// a character that decodes to the given count, never a newline
	function automatic logic [7:0] count_char(input logic [5:0] n);
		logic [7:0] c;
		c = {2'($urandom_range(0, 3)), 6'd0} + {2'b00, n} + CHAR_SPACE;
		if (c == CHAR_NL)
			c = {2'b00, n} + CHAR_SPACE;
		return c;
	endfunction

	// stimulus
	initial begin
		int          count;
		int          len;
		int          cut;
		int          ending;
		int          pos;
		logic [7:0]  c;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = 1'b0;
		m_tready     = 1'b0;
		row_typed    = 1'b0;
		row_has      = 1'b0;
		row_res      = '0;
		dec_phase    = PH_SEARCH;
		dec_match    = '0;
		dec_left     = '0;
		dec_group    = '0;
		dec_prev     = '0;
		dec_total    = '0;
		mismatches   = 0;
		items_sent   = 0;
		idle_mode    = 0;
		stall_cycles = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows
		for (int i = 0; i < N_DIRECTED; i++)
			send_char(DIRECTED[i].ch, DIRECTED[i].eoi, DIRECTED[i].typed,
				DIRECTED[i].has_res, DIRECTED[i].res);

		// hold off until the block has delivered everything
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);

		// random data lines, mostly well formed
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 5) begin
				send_char(CHAR_NL, 1'b0);
			end else begin
				count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 63)
					: $urandom_range(1, 15);
				send_char(count_char(6'(count)), 1'b0);
				len = ((count + 2) / 3) * 4 + $urandom_range(0, 3);
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
				for (int i = 0; i < cut; i++)
					send_char(data_char(), 1'b0);
				send_char(CHAR_NL, 1'b0);
			end
		end

		// closing: clean trailer, end of input mid-line, or broken trailer
		ending = $urandom_range(0, 2);
		if (ending == 1) begin
			send_char(count_char(6'($urandom_range(1, 63))), 1'b0);
			repeat ($urandom_range(0, 6))
				send_char(data_char(), 1'b0);
			send_char(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			send_char(count_char(6'd0), 1'b0);
			repeat ($urandom_range(0, 3))
				send_char(data_char(), 1'b0);
			send_char(CHAR_NL, 1'b0);
			pos = (ending == 0) ? 4 : $urandom_range(0, 3);
			for (int i = 0; i < pos; i++)
				send_char(END_TEXT[8 * (3 - i) +: 8], 1'b0);
			if (ending == 2) begin
				do c = 8'($urandom_range(0, 255)); while (c == END_TEXT[8 * (3 - pos) +: 8]);
				send_char(c, 1'b0);
			end
		end

		// characters after the report are dropped without a result
		repeat (8)
			send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		s_tvalid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
